[rtl/met_pkg.sv]
// shared types and constants for the mandelbrot escape-time block
`timescale 1ns / 1ps
package met_pkg;

	// coordinate and result field widths
	localparam int C_W = 32;
	localparam int CNT_OUT_W = 16;
	localparam int THRESH_W = 35;

	// z components stay well below 2^37 in magnitude
	localparam int Z_W = 38;
	localparam int MAG_W = 38;
	localparam int HALF_W = MAG_W / 2;
	localparam int PROD_W = 2 * MAG_W;

	// squares that pass the escape test fit in this many bits
	localparam int SQ_KEEP = 36;

	// register indexes
	localparam logic [1:0] REG_MAX_ITER = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;

	localparam int ITER_RESET = 128;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 35'd2147483648;

	typedef struct packed {
		logic start;
		logic [MAG_W-1:0] a;
		logic [MAG_W-1:0] b;
	} mul_req_t;

endpackage

[rtl/met_mul.sv]
// sequential unsigned multiplier built around one shared half-width multiplier
`timescale 1ns / 1ps
module met_mul
	import met_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  mul_req_t req,
	output logic done,
	output logic [PROD_W-1:0] p
);

	logic busy_q;
	logic [1:0] step_q;
	logic vld_s1;
	logic last_s1;
	logic done_q;
	logic [MAG_W-1:0] a_q;
	logic [MAG_W-1:0] b_q;
	logic [2*HALF_W-1:0] pp_s1;
	logic [1:0] sh_s1;
	logic [PROD_W-1:0] acc_q;
	logic [HALF_W-1:0] a_half;
	logic [HALF_W-1:0] b_half;
	logic [PROD_W-1:0] pp_ext;
	logic [PROD_W-1:0] pp_shifted;

	// step bit 0 picks the half of a, bit 1 the half of b
	assign a_half = step_q[0] ? a_q[MAG_W-1:HALF_W] : a_q[HALF_W-1:0];
	assign b_half = step_q[1] ? b_q[MAG_W-1:HALF_W] : b_q[HALF_W-1:0];

	assign pp_ext = PROD_W'(pp_s1);

	always_comb begin
		case (sh_s1)
			2'd0: pp_shifted = pp_ext;
			2'd1: pp_shifted = pp_ext << HALF_W;
			2'd2: pp_shifted = pp_ext << (2 * HALF_W);
			default: pp_shifted = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			vld_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
			last_s1 <= busy_q && (step_q == 2'd3);
			done_q <= vld_s1 && last_s1;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_s1 <= a_half * b_half;
		sh_s1 <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + pp_shifted;
		end
	end

	assign done = done_q;
	assign p = acc_q;

endmodule

[rtl/mandelbrot_escape_time_top.sv]
// mandelbrot escape-time unit: iterates z = z*z + c on one shared multiplier
//
// channel   dir  signals                          content
// s_axis    in   tvalid tready tdata[63:0]        c_re, c_im (signed, FRACTION_BITS fraction)
// m_axis    out  tvalid tready tdata[15:0] tuser  iter_count; in_set
// cfg       in   cfg_we cfg_index[1:0] cfg_data   0 max_iterations, 1 escape_threshold
//
// each iteration forms three 38x38 products on a 19x19 multiplier, four passes per product.
// s_axis_tready is high only while no pixel is in work; a full result register
// holds a finished pixel in its last state until the old beat is taken.
// the next pixel can be accepted while a result waits. reset restores the register defaults.
`timescale 1ns / 1ps
module mandelbrot_escape_time_top
	import met_pkg::*;
#(
	parameter int FRACTION_BITS = 27,
	parameter int COUNT_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // c_re [31:0], c_im [63:32]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata,   // iter_count [15:0]
	output logic [0:0] m_axis_tuser,    // in_set [0]
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [THRESH_W-1:0] cfg_data
);

	localparam int SQ_W = PROD_W - FRACTION_BITS;
	localparam int CNT_MAX = (1 << COUNT_WIDTH) - 1;
	localparam logic [COUNT_WIDTH-1:0] MAX_RST =
		COUNT_WIDTH'((ITER_RESET > CNT_MAX) ? CNT_MAX : ITER_RESET);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TEST = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_SQI  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_CRS  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic [COUNT_WIDTH-1:0] max_q;
	logic [THRESH_W-1:0] thr_q;
	logic [COUNT_WIDTH-1:0] iter_q;
	logic signed [Z_W-1:0] re_q;
	logic signed [Z_W-1:0] im_q;
	logic signed [Z_W-1:0] cr_q;
	logic signed [Z_W-1:0] ci_q;
	logic [SQ_W-1:0] sqre_q;
	logic [SQ_W-1:0] sqim_q;
	logic mvalid_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;
	logic in_set_q;

	mul_req_t mul_req;
	logic mul_done;
	logic [PROD_W-1:0] mul_p;

	logic in_acc;
	logic [MAG_W-1:0] ar;
	logic [MAG_W-1:0] ai;
	logic at_limit;
	logic escaped;
	logic [SQ_W:0] sq_sum;
	logic [PROD_W-1:0] sq_full;
	logic [PROD_W-1:0] crs_full;
	logic signed [Z_W-1:0] crs;
	logic signed [Z_W-1:0] sqre_z;
	logic signed [Z_W-1:0] sqim_z;
	logic signed [Z_W-1:0] re_next;
	logic signed [Z_W-1:0] im_next;
	logic [CNT_OUT_W-1:0] lim_val;
	logic out_free;

	met_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free = !mvalid_q || m_axis_tready;

	assign ar = re_q[Z_W-1] ? MAG_W'(-re_q) : MAG_W'(re_q);
	assign ai = im_q[Z_W-1] ? MAG_W'(-im_q) : MAG_W'(im_q);

	assign at_limit = (iter_q == max_q);
	assign sq_sum = {1'b0, sqre_q} + {1'b0, sqim_q};
	assign escaped = sq_sum > (SQ_W + 1)'(thr_q);

	assign sq_full = mul_p >> FRACTION_BITS;
	// cross term: (2 * |re| * |im|) >> FRACTION_BITS, truncated toward zero
	assign crs_full = mul_p >> (FRACTION_BITS - 1);
	assign crs = $signed({1'b0, crs_full[Z_W-2:0]});

	assign sqre_z = $signed({{(Z_W - SQ_KEEP){1'b0}}, sqre_q[SQ_KEEP-1:0]});
	assign sqim_z = $signed({{(Z_W - SQ_KEEP){1'b0}}, sqim_q[SQ_KEEP-1:0]});
	assign re_next = sqre_z - sqim_z + cr_q;
	assign im_next = (re_q[Z_W-1] ^ im_q[Z_W-1]) ? (ci_q - crs) : (ci_q + crs);

	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a = ar;
		mul_req.b = ar;
		case (state_q)
			ST_TEST: begin
				mul_req.start = !at_limit;
			end
			ST_SQR: begin
				mul_req.start = mul_done;
				mul_req.a = ai;
				mul_req.b = ai;
			end
			ST_CHK: begin
				mul_req.start = !escaped;
				mul_req.b = ai;
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	// limit write keeps the low 16 data bits, saturated to the counter range
	assign lim_val = cfg_data[CNT_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q <= MAX_RST;
			thr_q <= THRESH_RESET;
			mvalid_q <= 1'b0;
			iter_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ITER: begin
						if ((lim_val >> COUNT_WIDTH) != '0) begin
							max_q <= '1;
						end else begin
							max_q <= lim_val[COUNT_WIDTH-1:0];
						end
					end
					REG_THRESH: begin
						thr_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				mvalid_q <= 1'b1;
			end else if (mvalid_q && m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						iter_q <= '0;
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					state_q <= at_limit ? ST_DONE : ST_SQR;
				end
				ST_SQR: begin
					if (mul_done) begin
						state_q <= ST_SQI;
					end
				end
				ST_SQI: begin
					if (mul_done) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					state_q <= escaped ? ST_DONE : ST_CRS;
				end
				ST_CRS: begin
					if (mul_done) begin
						iter_q <= iter_q + COUNT_WIDTH'(1);
						state_q <= ST_TEST;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cr_q <= Z_W'($signed(s_axis_tdata[C_W-1:0]));
			ci_q <= Z_W'($signed(s_axis_tdata[2*C_W-1:C_W]));
			re_q <= Z_W'($signed(s_axis_tdata[C_W-1:0]));
			im_q <= Z_W'($signed(s_axis_tdata[2*C_W-1:C_W]));
		end
		if (state_q == ST_SQR && mul_done) begin
			sqre_q <= sq_full[SQ_W-1:0];
		end
		if (state_q == ST_SQI && mul_done) begin
			sqim_q <= sq_full[SQ_W-1:0];
		end
		if (state_q == ST_CRS && mul_done) begin
			re_q <= re_next;
			im_q <= im_next;
		end
		if (state_q == ST_DONE && out_free) begin
			cnt_out_q <= CNT_OUT_W'(iter_q);
			in_set_q <= at_limit;
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata = cnt_out_q;
	assign m_axis_tuser = in_set_q;

endmodule

[tb/tb_top.sv]
// testbench for the mandelbrot escape-time unit: random and directed pixels against a predictor
`timescale 1ns / 1ps
module tb_top;
	import met_pkg::*;

	localparam int FRAC_BITS = 27;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int SEGMENTS = 15;
	localparam int SEG_PIXELS = 50;
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;
	localparam logic [31:0] FX_ONE = 32'd134217728;
	localparam logic [31:0] FX_MIN = 32'h8000_0000;
	localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
	localparam logic [THRESH_W-1:0] THRESH_TOP = {THRESH_W{1'b1}};
	localparam logic [THRESH_W-1:0] THRESH_FOUR = 35'd536870912;

	typedef struct {
		logic [15:0] count;
		logic in_set;
	} escape_result_t;

	class escape_scoreboard;
		logic [15:0] max_iter;
		logic [THRESH_W-1:0] thresh;
		escape_result_t expected_q[$];
		int errors;
		int checked;
		int inset_seen;

		function new();
			max_iter = 16'(ITER_RESET);
			thresh = THRESH_RESET;
			errors = 0;
			checked = 0;
			inset_seen = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [THRESH_W-1:0] data);
			case (index)
				REG_MAX_ITER: max_iter = data[15:0];
				REG_THRESH: thresh = data;
				default: ;
			endcase
		endfunction

		function escape_result_t escape_time(logic signed [31:0] c_re, logic signed [31:0] c_im);
			longint cr, ci, re, im;
			longint unsigned ar, ai, sq_re, sq_im, cross_mag;
			logic [127:0] prod;
			int unsigned n;
			escape_result_t r;
			cr = c_re;
			ci = c_im;
			re = cr;
			im = ci;
			n = 0;
			while (n < max_iter) begin
				ar = (re < 0) ? -re : re;
				ai = (im < 0) ? -im : im;
				prod = {64'd0, ar} * {64'd0, ar};
				sq_re = prod[FRAC_BITS +: 64];
				prod = {64'd0, ai} * {64'd0, ai};
				sq_im = prod[FRAC_BITS +: 64];
				if (sq_re + sq_im > 64'(thresh))
					break;
				// cross term works on magnitudes, so it truncates toward zero
				prod = {64'd0, ar << 1} * {64'd0, ai};
				cross_mag = prod[FRAC_BITS +: 64];
				if ((re < 0) != (im < 0))
					im = ci - $signed(cross_mag);
				else
					im = ci + $signed(cross_mag);
				re = $signed(sq_re) - $signed(sq_im) + cr;
				n++;
			end
			r.count = n[15:0];
			r.in_set = (n == max_iter);
			return r;
		endfunction

		function void note_pixel(logic [31:0] c_re, logic [31:0] c_im);
			expected_q.push_back(escape_time(c_re, c_im));
		endfunction

		function void check_result(logic [15:0] count, logic in_set);
			escape_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result beat with no pixel outstanding: iter_count %0d in_set %0b",
					count, in_set);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			if (exp_r.in_set)
				inset_seen++;
			if (count !== exp_r.count) begin
				$error("iter_count: expected %0d, got %0d", exp_r.count, count);
				errors++;
			end
			if (in_set !== exp_r.in_set) begin
				$error("in_set: expected %0b, got %0b", exp_r.in_set, in_set);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata;   // c_re [31:0], c_im [63:32]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;   // iter_count [15:0]
	logic [0:0] m_axis_tuser;    // in_set [0]
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [THRESH_W-1:0] cfg_data;

	escape_scoreboard sb = new();
	int src_idle_pct = 33;
	int rcv_idle_pct = 78;
	int hold_cycles = 0;
	int cycles = 0;
	int cfg_writes = 0;

	mandelbrot_escape_time_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stalls, or a long hold-off while hold_cycles runs down
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// all tasks start and return just after a falling edge
	task automatic send_pixel(input logic [31:0] c_re, input logic [31:0] c_im);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c_im, c_re};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_pixel(c_re, c_im);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] index, input logic [THRESH_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		sb.write_reg(index, data);
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	// limit write with junk above the 16 register bits
	function automatic logic [THRESH_W-1:0] limit_word(logic [15:0] limit);
		logic [63:0] w;
		w = {$urandom, $urandom};
		w[15:0] = limit;
		return w[THRESH_W-1:0];
	endfunction

	function automatic logic [63:0] random_point();
		int unsigned sel;
		logic [31:0] re, im;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			// window around the set: re in [-2.5, 1.0], im in [-1.5, 1.5]
			re = $urandom_range(0, 469762048) - 335544320;
			im = $urandom_range(0, 402653184) - 201326592;
		end else if (sel < 85) begin
			re = $urandom;
			im = $urandom;
		end else if (sel < 93) begin
			re = $urandom_range(0, 255) - 128;
			im = $urandom_range(0, 255) - 128;
		end else begin
			re = $urandom_range(0, 1) ? FX_MIN : FX_MAX;
			im = $urandom_range(0, 1) ? FX_MIN : $urandom;
		end
		return {im, re};
	endfunction

	initial begin
		logic [63:0] pt;
		logic [63:0] w;
		logic [15:0] limit;
		logic [THRESH_W-1:0] thr;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MAX_ITER;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// register defaults: origin, corners, real axis, both cross-term signs
		send_pixel(32'd0, 32'd0);
		send_pixel(FX_MIN, FX_MIN);
		send_pixel(FX_MAX, FX_MAX);
		send_pixel(FX_MIN, FX_MAX);
		send_pixel(-(FX_ONE * 2), 32'd0);
		send_pixel(FX_ONE / 4, 32'd0);
		send_pixel(FX_ONE, 32'd0);
		send_pixel(-(FX_ONE * 3 / 4), FX_ONE / 10);
		send_pixel(FX_ONE * 3 / 10, -(FX_ONE / 2));
		wait_results_done();

		// zero limit: no iteration at all
		cfg_write(REG_MAX_ITER, limit_word(16'd0));
		send_pixel(FX_ONE / 10, FX_ONE / 10);
		send_pixel(FX_MIN, FX_MAX);
		wait_results_done();

		// writes to unused indexes must leave both registers alone
		w = {$urandom, $urandom};
		cfg_write(REG_SPARE_2, w[THRESH_W-1:0]);
		w = {$urandom, $urandom};
		cfg_write(REG_SPARE_3, w[THRESH_W-1:0]);
		send_pixel(FX_ONE / 10, -(FX_ONE / 10));
		wait_results_done();

		// widest limit and threshold, only points that escape
		cfg_write(REG_MAX_ITER, limit_word(16'hFFFF));
		cfg_write(REG_THRESH, THRESH_TOP);
		send_pixel(FX_ONE, FX_ONE);
		send_pixel(FX_MIN, 32'd0);
		send_pixel(FX_MAX, 32'd0);
		send_pixel(FX_ONE / 2, FX_ONE / 2);
		wait_results_done();

		// zero threshold: anything with a nonzero square escapes at once
		cfg_write(REG_MAX_ITER, limit_word(16'd1));
		cfg_write(REG_THRESH, '0);
		send_pixel(32'd0, 32'd0);
		send_pixel(FX_ONE, 32'd0);
		send_pixel(32'd1, 32'd1);
		wait_results_done();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 5)
				0: begin
					src_idle_pct = 33;
					rcv_idle_pct = 78;
				end
				1: begin
					src_idle_pct = 78;
					rcv_idle_pct = 33;
				end
				default: begin
					src_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			case (seg % 5)
				0: limit = 16'($urandom_range(1, 16));
				1: limit = 16'($urandom_range(17, 48));
				2: limit = 16'd1;
				3: limit = 16'($urandom_range(2, 64));
				default: limit = 16'd32;
			endcase
			case (seg % 4)
				0: thr = THRESH_RESET;
				1: thr = THRESH_TOP;
				2: begin
					w = {$urandom, $urandom};
					thr = w[THRESH_W-1:0];
				end
				default: thr = THRESH_FOUR;
			endcase
			if (seg == 13)
				thr = '0;
			cfg_write(REG_MAX_ITER, limit_word(limit));
			cfg_write(REG_THRESH, thr);
			// hold off the result side so the block backs up onto its input
			if (seg == 2)
				hold_cycles = 4000;
			for (int k = 0; k < SEG_PIXELS; k++) begin
				if (seg == 7 && k == SEG_PIXELS / 2)
					wait_results_done();
				pt = random_point();
				send_pixel(pt[31:0], pt[63:32]);
			end
			wait_results_done();
		end

		repeat (50) @(negedge clk);
		$display("%0d pixels checked (%0d inside the set) across %0d register writes",
			sb.checked, sb.inset_seen, cfg_writes);
		$display("limits 0..65535, thresholds 0..max, three stall mixes and a long hold-off");
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
